FILE: hw/rtl/rclfr_pkg.sv
package rclfr_pkg;

    // line item opcodes
    localparam logic [1:0] OP_DATA      = 2'd0;
    localparam logic [1:0] OP_OVERFLOW  = 2'd1;
    localparam logic [1:0] OP_LINE_ERR  = 2'd2;
    localparam logic [1:0] OP_BREAK     = 2'd3;

    // result event codes
    localparam logic [1:0] EV_RC        = 2'd0;
    localparam logic [1:0] EV_FRAME     = 2'd1;
    localparam logic [1:0] EV_CRC_ERR   = 2'd2;
    localparam logic [1:0] EV_FRAME_ERR = 2'd3;

    // command codes
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_ESTOP    = 3'd1;
    localparam logic [2:0] CMD_DISARM   = 3'd2;
    localparam logic [2:0] CMD_ARM      = 3'd3;
    localparam logic [2:0] CMD_SET_MODE = 3'd4;

    // configuration register indexes
    localparam logic [3:0] CFG_SYNC       = 4'd0;
    localparam logic [3:0] CFG_RC_TYPE    = 4'd1;
    localparam logic [3:0] CFG_STATS_TYPE = 4'd2;
    localparam logic [3:0] CFG_THRESHOLD  = 4'd3;
    localparam logic [3:0] CFG_REPEAT     = 4'd4;
    localparam logic [3:0] CFG_ARM_CH     = 4'd5;
    localparam logic [3:0] CFG_MODE_CH    = 4'd6;
    localparam logic [3:0] CFG_KILL_CH    = 4'd7;

    // frame format
    localparam logic [7:0] CRC_POLY          = 8'hD5;
    localparam int         MIN_LEN           = 2;
    localparam int         RC_PAYLOAD_BYTES  = 22;
    localparam int         STATS_MIN_PAYLOAD = 10;
    localparam int         CH_BITS           = 11;
    localparam int         DECODED_CHANNELS  = 16;
    localparam int         PAYLOAD_BITS      = RC_PAYLOAD_BYTES * 8;
    localparam int         QUEUE_DEPTH       = 2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  frame_kind;
        logic [3:0]  channel_number;
        logic [10:0] channel_value;
        logic        arm_high;
        logic        mode_high;
        logic        kill_high;
        logic [7:0]  command_seq;
        logic [2:0]  command_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  sync_value;
        logic [7:0]  rc_type_code;
        logic [7:0]  stats_type_code;
        logic [10:0] switch_threshold;
        logic [7:0]  repeat_frames;
        logic [3:0]  arm_channel;
        logic [3:0]  mode_channel;
        logic [3:0]  kill_channel;
    } cfg_t;

    // one classified frame handed from the front end to the back end
    typedef struct packed {
        logic [1:0]              event_res;
        logic [7:0]              frame_kind;
        logic [PAYLOAD_BITS-1:0] payload;
    } frame_t;

    // one byte of crc-8, msb first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] x;
        x = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if ((x & 8'h80) != 8'h00)
            begin
                x = (x << 1) ^ CRC_POLY;
            end
            else
            begin
                x = x << 1;
            end
        end
        return x;
    endfunction

endpackage

FILE: hw/rtl/rclfr_queue.sv
module rclfr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  rclfr_pkg::frame_t wr_data,
    output logic              full,
    input  logic              rd,
    output rclfr_pkg::frame_t rd_data,
    output logic              empty
);
    import rclfr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/rclfr_front.sv
module rclfr_front #(
    parameter int FRAME_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rclfr_pkg::cfg_t   cfg,
    input  logic              push,
    input  rclfr_pkg::item_t  item,
    input  logic              q_full,
    output logic              enq,
    output rclfr_pkg::frame_t enq_frame
);
    import rclfr_pkg::*;

    localparam int PW      = $clog2(FRAME_BYTES + 1);
    localparam int MAX_LEN = FRAME_BYTES - 2;

    logic [PW-1:0]           pos_reg, pos_next;
    logic [PW-1:0]           total_reg, total_next;
    logic [7:0]              crc_reg, crc_next;
    logic [7:0]              kind_reg, kind_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;
    logic                    accept;
    logic [8:0]              pos9;
    logic [8:0]              total9;

    assign accept = push && !q_full;
    assign pos9   = 9'(pos_reg);
    assign total9 = 9'(total_reg);

    // hunt, length check, collection and classification
    always_comb
    begin
        pos_next             = pos_reg;
        total_next           = total_reg;
        crc_next             = crc_reg;
        kind_next            = kind_reg;
        payload_next         = payload_reg;
        enq                  = 1'b0;
        enq_frame.event_res  = EV_FRAME_ERR;
        enq_frame.frame_kind = 8'h00;
        enq_frame.payload    = payload_reg;
        if (accept)
        begin
            case (item.opcode)
                OP_OVERFLOW, OP_LINE_ERR:
                begin
                    pos_next   = '0;
                    total_next = '0;
                    enq        = 1'b1;
                end
                OP_BREAK:
                begin
                    pos_next   = '0;
                    total_next = '0;
                end
                OP_DATA:
                begin
                    if (pos_reg == '0)
                    begin
                        if (item.byte_value == cfg.sync_value)
                        begin
                            pos_next = PW'(1);
                        end
                    end
                    else if (pos_reg == PW'(1))
                    begin
                        if (item.byte_value < 8'(MIN_LEN) || item.byte_value > 8'(MAX_LEN))
                        begin
                            pos_next   = '0;
                            total_next = '0;
                            enq        = 1'b1;
                        end
                        else
                        begin
                            pos_next   = PW'(2);
                            total_next = PW'(item.byte_value) + PW'(2);
                            crc_next   = 8'h00;
                        end
                    end
                    else
                    begin
                        // type byte
                        if (pos_reg == PW'(2))
                        begin
                            kind_next = item.byte_value;
                        end
                        // crc covers type and payload, not the crc byte itself
                        if (pos9 + 9'd1 < total9)
                        begin
                            crc_next = crc8_step(crc_reg, item.byte_value);
                        end
                        // rc channel payload bytes, first byte ends up lowest
                        if (pos9 >= 9'd3 && pos9 <= 9'(RC_PAYLOAD_BYTES + 2))
                        begin
                            payload_next = {item.byte_value, payload_reg[PAYLOAD_BITS-1:8]};
                        end
                        pos_next = pos_reg + 1'b1;
                        // closing byte
                        if (pos9 + 9'd1 >= total9)
                        begin
                            pos_next             = '0;
                            total_next           = '0;
                            enq                  = 1'b1;
                            enq_frame.frame_kind = kind_reg;
                            if (item.byte_value != crc_reg)
                            begin
                                enq_frame.event_res = EV_CRC_ERR;
                            end
                            else if (kind_reg == cfg.rc_type_code)
                            begin
                                enq_frame.event_res =
                                    (total9 == 9'(RC_PAYLOAD_BYTES + 4)) ? EV_RC : EV_FRAME_ERR;
                            end
                            else if (kind_reg == cfg.stats_type_code &&
                                     total9 < 9'(STATS_MIN_PAYLOAD + 4))
                            begin
                                enq_frame.event_res = EV_FRAME_ERR;
                            end
                            else
                            begin
                                enq_frame.event_res = EV_FRAME;
                            end
                        end
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
        end
    end

    // frame data
    always_ff @(posedge clk)
    begin
        crc_reg     <= crc_next;
        kind_reg    <= kind_next;
        payload_reg <= payload_next;
    end

endmodule

FILE: hw/rtl/rclfr_back.sv
module rclfr_back #(
    parameter int CHANNELS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rclfr_pkg::cfg_t    cfg,
    input  logic               q_empty,
    input  rclfr_pkg::frame_t  q_head,
    output logic               q_pop,
    output rclfr_pkg::result_t result,
    output logic               empty,
    input  logic               pop
);
    import rclfr_pkg::*;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } bk_state_t;

    bk_state_t               state_reg, state_next;
    logic [3:0]              idx_reg, idx_next;
    logic [PAYLOAD_BITS-1:0] work_reg, work_next;
    logic [7:0]              kind_reg, kind_next;
    logic [2:0]              sw_reg, sw_next;
    logic [2:0]              code_reg, code_next;
    logic                    known_reg, known_next;
    logic                    alo_reg, alo_next;
    logic [7:0]              seq_reg, seq_next;
    logic [2:0]              pend_reg, pend_next;
    logic [7:0]              left_reg, left_next;
    result_t                 res_reg, res_next;
    logic                    res_valid_reg, res_valid_next;

    logic                    out_ready;
    logic [CH_BITS-1:0]      arm_val, mode_val, kill_val;
    logic                    arm, mode, kill;
    logic                    new_cmd;
    logic [2:0]              cmd;

    assign empty     = !res_valid_reg;
    assign result    = res_reg;
    assign out_ready = !res_valid_reg || pop;

    // switch channels are picked by configuration from the decoded channels of the frame at the head
    assign arm_val  = q_head.payload[CH_BITS * cfg.arm_channel +: CH_BITS];
    assign mode_val = q_head.payload[CH_BITS * cfg.mode_channel +: CH_BITS];
    assign kill_val = q_head.payload[CH_BITS * cfg.kill_channel +: CH_BITS];
    assign arm      = arm_val > cfg.switch_threshold;
    assign mode     = mode_val > cfg.switch_threshold;
    assign kill     = kill_val > cfg.switch_threshold;

    // edge rules, highest priority first
    always_comb
    begin
        new_cmd = 1'b1;
        cmd     = CMD_NONE;
        if (!known_reg)
        begin
            cmd = kill ? CMD_ESTOP : CMD_SET_MODE;
        end
        else if (kill && !sw_reg[2])
        begin
            cmd = CMD_ESTOP;
        end
        else if (!arm && sw_reg[0])
        begin
            cmd = CMD_DISARM;
        end
        else if (arm && !sw_reg[0] && alo_reg && !kill)
        begin
            cmd = CMD_ARM;
        end
        else if (mode != sw_reg[1])
        begin
            cmd = CMD_SET_MODE;
        end
        else
        begin
            new_cmd = 1'b0;
        end
    end

    // frame dispatch and channel emit sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        work_next      = work_reg;
        kind_next      = kind_reg;
        sw_next        = sw_reg;
        code_next      = code_reg;
        known_next     = known_reg;
        alo_next       = alo_reg;
        seq_next       = seq_reg;
        pend_next      = pend_reg;
        left_next      = left_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_head.event_res == EV_RC)
                    begin
                        q_pop      = 1'b1;
                        state_next = BK_EMIT;
                        idx_next   = '0;
                        work_next  = q_head.payload;
                        kind_next  = q_head.frame_kind;
                        sw_next    = {kill, mode, arm};
                        known_next = 1'b1;
                        if (!known_reg)
                        begin
                            alo_next = !arm;
                        end
                        else if (!arm)
                        begin
                            alo_next = 1'b1;
                        end
                        if (new_cmd)
                        begin
                            seq_next  = seq_reg + 1'b1;
                            pend_next = cmd;
                            left_next = cfg.repeat_frames;
                        end
                        // carry the pending command while repeats remain
                        code_next = CMD_NONE;
                        if (left_next != 8'd0)
                        begin
                            code_next = pend_next;
                            left_next = left_next - 1'b1;
                            if (left_next == 8'd0)
                            begin
                                pend_next = CMD_NONE;
                            end
                        end
                    end
                    else if (out_ready)
                    begin
                        q_pop                   = 1'b1;
                        res_valid_next          = 1'b1;
                        res_next                = '0;
                        res_next.event_res      = q_head.event_res;
                        res_next.frame_kind     = q_head.frame_kind;
                        res_next.last           = 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                if (out_ready)
                begin
                    res_valid_next          = 1'b1;
                    res_next.event_res      = EV_RC;
                    res_next.frame_kind     = kind_reg;
                    res_next.channel_number = idx_reg;
                    res_next.channel_value  = work_reg[CH_BITS-1:0];
                    res_next.arm_high       = sw_reg[0];
                    res_next.mode_high      = sw_reg[1];
                    res_next.kill_high      = sw_reg[2];
                    res_next.command_seq    = seq_reg;
                    res_next.command_code   = code_reg;
                    res_next.last           = (idx_reg == 4'(CHANNELS - 1));
                    work_next               = work_reg >> CH_BITS;
                    idx_next                = idx_reg + 1'b1;
                    if (idx_reg == 4'(CHANNELS - 1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            sw_reg        <= '0;
            known_reg     <= 1'b0;
            alo_reg       <= 1'b0;
            seq_reg       <= '0;
            pend_reg      <= CMD_NONE;
            left_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sw_reg        <= sw_next;
            known_reg     <= known_next;
            alo_reg       <= alo_next;
            seq_reg       <= seq_next;
            pend_reg      <= pend_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // frame data and result payload
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        kind_reg <= kind_next;
        code_reg <= code_next;
        res_reg  <= res_next;
    end

endmodule

FILE: hw/rtl/rc_link_frame_receiver_top.sv
// Receiver for a serial RC link frame format with a CRC-8 (polynomial 0xD5). Each
// input transaction is a received byte or a line event; the front end handles one
// per clock while the queue is not full, hunting for the sync byte, checking the
// length, running the CRC and classifying the finished frame. A classified frame
// waits in a two-entry queue for the back end, and the input reports full only
// while both entries are taken. Errors and non-RC frames give one result; a good
// RC frame gives a decision step (switch compare and command rules) and then
// CHANNELS results, one per clock while the output is not held, counted by the
// back end's channel counter. Results leave through a single output register, and
// the configuration port is always ready.
module rc_link_frame_receiver_top #(
    parameter int FRAME_BYTES = 64,
    parameter int CHANNELS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rclfr_pkg::item_t   item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output rclfr_pkg::result_t result
);
    import rclfr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   q_full;
    logic   q_empty;
    logic   enq;
    logic   q_pop;
    frame_t enq_frame;
    frame_t q_head;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYNC:       cfg_next.sync_value       = cfg_data[7:0];
                CFG_RC_TYPE:    cfg_next.rc_type_code     = cfg_data[7:0];
                CFG_STATS_TYPE: cfg_next.stats_type_code  = cfg_data[7:0];
                CFG_THRESHOLD:  cfg_next.switch_threshold = cfg_data;
                CFG_REPEAT:     cfg_next.repeat_frames    = cfg_data[7:0];
                CFG_ARM_CH:     cfg_next.arm_channel      = cfg_data[3:0];
                CFG_MODE_CH:    cfg_next.mode_channel     = cfg_data[3:0];
                CFG_KILL_CH:    cfg_next.kill_channel     = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_value       <= 8'd200;
            cfg_reg.rc_type_code     <= 8'd22;
            cfg_reg.stats_type_code  <= 8'd20;
            cfg_reg.switch_threshold <= 11'd1300;
            cfg_reg.repeat_frames    <= 8'd5;
            cfg_reg.arm_channel      <= 4'd4;
            cfg_reg.mode_channel     <= 4'd5;
            cfg_reg.kill_channel     <= 4'd6;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // byte parser and frame classifier
    rclfr_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .item      (item),
        .q_full    (q_full),
        .enq       (enq),
        .enq_frame (enq_frame)
    );

    // classified frame queue
    rclfr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (enq),
        .wr_data (enq_frame),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // command rules and result emitter
    rclfr_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
